FILE: hw/rtl/tag_presence_qualifier_core_assert.svh
// Assertion macros used by the checker file of the tag presence qualifier.
`ifndef TAG_PRESENCE_QUALIFIER_CORE_ASSERT_SVH
`define TAG_PRESENCE_QUALIFIER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define TPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("tpq assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define TPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("tpq assertion failed");

`endif

FILE: hw/rtl/tpq_pkg.sv
// Types and constants of the tag presence qualifier.
package tpq_pkg;

    // Result status codes
    localparam logic [2:0] ST_NO_TAG     = 3'd0;
    localparam logic [2:0] ST_SAME       = 3'd1;
    localparam logic [2:0] ST_SETTLING   = 3'd2;
    localparam logic [2:0] ST_REMOVED    = 3'd3;
    localparam logic [2:0] ST_READER_ERR = 3'd4;
    localparam logic [2:0] ST_NEW        = 3'd5;
    localparam logic [2:0] ST_UNREADABLE = 3'd6;

    // Tag family codes
    localparam logic [1:0] FAM_SEVEN = 2'd0;
    localparam logic [1:0] FAM_FOUR  = 2'd1;
    localparam logic [1:0] FAM_OTHER = 2'd2;

    // Register indexes
    localparam logic REG_DWELL   = 1'b0;
    localparam logic REG_ABSENCE = 1'b1;

    localparam logic [15:0] DWELL_RESET   = 16'd1000;
    localparam logic [15:0] ABSENCE_RESET = 16'd3000;

    localparam logic [2:0] QUIET_PER_PROBE = 3'd5;
    localparam logic [1:0] FAIL_LIMIT      = 2'd3;
    localparam logic [3:0] GOOD_PER_REARM  = 4'd10;
    localparam logic [3:0] LEN_SEVEN       = 4'd7;
    localparam logic [3:0] LEN_FOUR        = 4'd4;

    localparam int IN_W  = 120;
    localparam int OUT_W = 8;

    // Input word, first field in the highest bits
    typedef struct packed {
        logic        decoded_ok;
        logic        probe_ok;
        logic [31:0] now_ms;
        logic [3:0]  uid_len;
        logic [15:0] uid_high;
        logic [63:0] uid_low;
        logic        tag_seen;
        logic        reader_ready;
    } in_word_t;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic       rearm;
        logic       probe_issued;
        logic [1:0] tag_family;
        logic [2:0] status;
    } out_word_t;

endpackage

FILE: hw/rtl/tag_presence_qualifier_core.sv
// Top level of the tag presence qualifier: poll in, one status word out.
//
// Use: feed one reader poll per word on the s_ stream and take one status
// word per poll from the m_ stream, in order. dwell_ms and absence_ms are
// set on the plain write port (cfg_wr_en, cfg_index, cfg_wdata) while idle.
//
// A poll accepted on the s_ stream is registered in the input register,
// evaluated against the tracking state and loads the result register once
// the result register is empty or its word is being taken (m_tready high).
// Throughput: one poll per cycle while m_tready stays high, set by the single
// evaluate step between the input register and the result register; the state
// update for poll k lands in the same edge that loads poll k+1's input register.
//
// Stall: while m_tready is low the result word holds; the input register
// still fills once, then s_tready drops until the result is taken.
//
// Reset (aresetn low, synchronous): both stages empty, counters, held tag,
// candidate and lost time cleared, dwell_ms back to 1000, absence_ms to 3000.
module tag_presence_qualifier_core #(
    parameter int MAX_UID_BYTES = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // fields from bit 0: reader_ready, tag_seen, uid_low[64], uid_high[16],
    // uid_len[4], now_ms[32], probe_ok, decoded_ok
    input  logic [tpq_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // fields from bit 0: status[3], tag_family[2], probe_issued, rearm, pad
    output logic [tpq_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_wdata
);
    import tpq_pkg::*;

    localparam int UID_W = MAX_UID_BYTES * 8;
    localparam logic [3:0] MAX_LEN = 4'(MAX_UID_BYTES);

    // Configuration
    logic [15:0] dwell_reg, absence_reg;

    // Pipeline stages
    logic      in_valid_reg, out_valid_reg;
    in_word_t  in_reg;
    out_word_t out_reg, out_next;
    logic      advance;

    // Tracking state
    logic [2:0]       quiet_reg, quiet_next;
    logic [1:0]       fail_reg, fail_next;
    logic [3:0]       good_reg, good_next;
    logic [UID_W-1:0] held_uid_reg, held_uid_next;
    logic [3:0]       held_len_reg, held_len_next;
    logic [UID_W-1:0] cand_uid_reg, cand_uid_next;
    logic [3:0]       cand_len_reg, cand_len_next;
    logic [31:0]      cand_first_reg, cand_first_next;
    logic [31:0]      lost_reg, lost_next;

    // Evaluate helpers
    logic [79:0]      uid_full;
    logic [3:0]       len_sat;
    logic [UID_W-1:0] uid_masked;
    logic [31:0]      lost_eff, lost_age, cand_age;
    logic             probe_done;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // Saturate the length and drop bytes beyond it
    assign uid_full = {in_reg.uid_high, in_reg.uid_low};
    assign len_sat  = (in_reg.uid_len > MAX_LEN) ? MAX_LEN : in_reg.uid_len;

    always_comb begin
        for (int b = 0; b < MAX_UID_BYTES; b++) begin
            uid_masked[b*8 +: 8] = (4'(b) < len_sat) ? uid_full[b*8 +: 8] : 8'h00;
        end
    end

    // A loss first seen at time zero is recorded as one
    assign lost_eff = (lost_reg != 32'd0) ? lost_reg :
                      ((in_reg.now_ms != 32'd0) ? in_reg.now_ms : 32'd1);
    assign lost_age = in_reg.now_ms - lost_eff;
    assign cand_age = in_reg.now_ms - cand_first_reg;

    always_comb begin
        quiet_next      = quiet_reg;
        fail_next       = fail_reg;
        good_next       = good_reg;
        held_uid_next   = held_uid_reg;
        held_len_next   = held_len_reg;
        cand_uid_next   = cand_uid_reg;
        cand_len_next   = cand_len_reg;
        cand_first_next = cand_first_reg;
        lost_next       = lost_reg;
        probe_done      = 1'b0;
        out_next        = '0;
        out_next.status = ST_NO_TAG;

        if (!in_reg.reader_ready) begin
            out_next.status = ST_NO_TAG;
        end else if (!in_reg.tag_seen) begin
            // Quiet poll: drop the candidate, maybe run a probe
            cand_uid_next = '0;
            cand_len_next = 4'd0;
            quiet_next    = quiet_reg + 3'd1;
            if (quiet_next >= QUIET_PER_PROBE) begin
                quiet_next            = 3'd0;
                out_next.probe_issued = 1'b1;
                if (!in_reg.probe_ok) begin
                    probe_done = 1'b1;
                    fail_next  = fail_reg + 2'd1;
                    if (fail_next < FAIL_LIMIT) begin
                        out_next.status = ST_NO_TAG;
                    end else begin
                        fail_next       = 2'd0;
                        out_next.status = ST_READER_ERR;
                    end
                end else begin
                    fail_next = 2'd0;
                    good_next = good_reg + 4'd1;
                    if (good_next >= GOOD_PER_REARM) begin
                        good_next      = 4'd0;
                        out_next.rearm = 1'b1;
                    end
                end
            end
            // Absence debounce, skipped after a failed probe
            if (!probe_done) begin
                if (held_len_reg != 4'd0) begin
                    if (lost_age < {16'd0, absence_reg}) begin
                        lost_next       = lost_eff;
                        out_next.status = ST_SAME;
                    end else begin
                        held_uid_next   = '0;
                        held_len_next   = 4'd0;
                        lost_next       = 32'd0;
                        out_next.status = ST_REMOVED;
                    end
                end else begin
                    out_next.status = ST_NO_TAG;
                end
            end
        end else begin
            lost_next  = 32'd0;
            quiet_next = 3'd0;
            case (len_sat)
                LEN_SEVEN: out_next.tag_family = FAM_SEVEN;
                LEN_FOUR:  out_next.tag_family = FAM_FOUR;
                default:   out_next.tag_family = FAM_OTHER;
            endcase
            // Stored UIDs are kept masked, so a full compare plus length suffices
            if (len_sat == held_len_reg && uid_masked == held_uid_reg) begin
                out_next.status = ST_SAME;
            end else if (len_sat != cand_len_reg || uid_masked != cand_uid_reg) begin
                cand_uid_next   = uid_masked;
                cand_len_next   = len_sat;
                cand_first_next = in_reg.now_ms;
                out_next.status = ST_SETTLING;
            end else if (cand_age < {16'd0, dwell_reg}) begin
                out_next.status = ST_SETTLING;
            end else begin
                held_uid_next = uid_masked;
                held_len_next = len_sat;
                if ((len_sat == LEN_SEVEN || len_sat == LEN_FOUR) && in_reg.decoded_ok) begin
                    out_next.status = ST_NEW;
                end else begin
                    out_next.status = ST_UNREADABLE;
                end
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg   <= DWELL_RESET;
            absence_reg <= ABSENCE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DWELL:   dwell_reg   <= cfg_wdata;
                REG_ABSENCE: absence_reg <= cfg_wdata;
                default:     dwell_reg   <= dwell_reg;
            endcase
        end
    end

    // Stage valids and tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            quiet_reg      <= '0;
            fail_reg       <= '0;
            good_reg       <= '0;
            held_uid_reg   <= '0;
            held_len_reg   <= '0;
            cand_uid_reg   <= '0;
            cand_len_reg   <= '0;
            cand_first_reg <= '0;
            lost_reg       <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                quiet_reg      <= quiet_next;
                fail_reg       <= fail_next;
                good_reg       <= good_next;
                held_uid_reg   <= held_uid_next;
                held_len_reg   <= held_len_next;
                cand_uid_reg   <= cand_uid_next;
                cand_len_reg   <= cand_len_next;
                cand_first_reg <= cand_first_next;
                lost_reg       <= lost_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_word_t'(s_tdata);
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

FILE: hw/rtl/tpq_checker.sv
// Port-level checker of the tag presence qualifier and its bind.
`include "tag_presence_qualifier_core_assert.svh"

module tpq_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic [tpq_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready
);
    import tpq_pkg::*;

    out_word_t ow;
    assign ow = out_word_t'(m_tdata[OUT_W-2:0]);

    // hold a stalled result word
    `TPQ_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // rearm only comes with a probe
    `TPQ_ASSERT_NOW(a_rearm_probe, m_tvalid && ow.rearm, ow.probe_issued)
    // reader error only comes from a probe
    `TPQ_ASSERT_NOW(a_err_probe, m_tvalid && ow.status == ST_READER_ERR, ow.probe_issued)
    // a probe runs on quiet polls only, where the family stays zero
    `TPQ_ASSERT_NOW(a_probe_quiet, m_tvalid && ow.probe_issued, ow.tag_family == FAM_SEVEN)
    // a nonzero family means a tag answered
    `TPQ_ASSERT_NOW(a_family_seen, m_tvalid && ow.tag_family != FAM_SEVEN,
        ow.status == ST_SAME || ow.status == ST_SETTLING ||
        ow.status == ST_NEW || ow.status == ST_UNREADABLE)

endmodule

bind tag_presence_qualifier_core tpq_checker u_tpq_checker (.*);
